/* rtl/core/rgbp_pkg.sv */
// Shared types, constants and helper functions for the radial glow backdrop pixel block.
// Depends on nothing; every other file of the block refers to it by scoped names.

package rgbp_pkg;

   // Field widths.
   localparam int COORD_BITS = 12;
   localparam int CFG_W      = 13;
   localparam int COLOR_W    = 8;

   // Glow geometry widths.
   localparam int CX_W     = 12;   // floor(3w/10) stays below 2458
   localparam int CY_W     = CFG_W - 3;
   localparam int RAD_W    = 13;   // floor(3w/5) stays below 4915
   localparam int DIFF_W   = (COORD_BITS > CX_W) ? COORD_BITS : CX_W;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int DIST_W   = SQ_W + 1;
   localparam int RAD2_W   = 2 * RAD_W;
   localparam int CMP_W    = (DIST_W > RAD2_W) ? DIST_W : RAD2_W;
   localparam int QUOT_W   = 6;
   localparam int REM_W    = RAD2_W + QUOT_W;
   localparam int TRIPLE_W = CFG_W + 2;

   // Colors and glow strength.
   localparam int INTENSITY_MAX = 36;
   localparam int BASE_RED      = 5;
   localparam int BASE_GREEN    = 6;
   localparam int BASE_BLUE     = 7;

   // Reciprocal of ten, scaled by 2^19; exact for dividends below 2^18.
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_TENTH = 52429;
   localparam int PROD_W      = TRIPLE_W + 16;

   // Reset values of the configuration registers and of the derived geometry.
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;
   localparam int CX_RESET     = FRAME_WIDTH_RESET * 3 / 10;
   localparam int CY_RESET     = FRAME_HEIGHT_RESET / 8;
   localparam int RADIUS_RESET = FRAME_WIDTH_RESET * 3 / 5;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [REM_W-1:0]  dividend;
      logic [RAD2_W-1:0] divisor;
      logic              in_glow;
   } div_in_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quot;
      logic              in_glow;
   } div_out_type;

   // 3*w times the scaled reciprocal of ten; shared by center and radius.
   function automatic logic [PROD_W-1:0] scaled_tenths(input logic [CFG_W-1:0] w);
      logic [TRIPLE_W-1:0] triple;
      triple = {2'b00, w} + {1'b0, w, 1'b0};
      return PROD_W'(triple) * PROD_W'(RECIP_TENTH);
   endfunction

   function automatic logic [CX_W-1:0] center_x(input logic [CFG_W-1:0] w);
      logic [PROD_W-1:0] prod;
      prod = scaled_tenths(w);
      return prod[RECIP_SHIFT +: CX_W];
   endfunction

   // floor(3w/5) is floor(3w/10) with one bit less of shift.
   function automatic logic [RAD_W-1:0] glow_radius(input logic [CFG_W-1:0] w);
      logic [PROD_W-1:0] prod;
      prod = scaled_tenths(w);
      return prod[RECIP_SHIFT-1 +: RAD_W];
   endfunction

   // floor(i/3) for i below 48, as a multiply by 43/128.
   function automatic logic [QUOT_W-3:0] third(input logic [QUOT_W-1:0] i);
      logic [QUOT_W+6:0] prod;
      prod = (QUOT_W+7)'(i) * (QUOT_W+7)'(43);
      return prod[7 +: QUOT_W-2];
   endfunction

endpackage

/* rtl/core/rgbp_div_pipe.sv */
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on rgbp_pkg for the operand widths and the stage payload types.

module rgbp_div_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rgbp_pkg::div_in_type     in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rgbp_pkg::div_out_type    out_data
);

   localparam int N = rgbp_pkg::QUOT_W;

   logic                           valid_ff    [N];
   logic [rgbp_pkg::REM_W-1:0]     rem_ff      [N];
   logic [rgbp_pkg::RAD2_W-1:0]    divisor_ff  [N];
   logic [rgbp_pkg::QUOT_W-1:0]    quot_ff     [N];
   logic                           in_glow_ff  [N];
   logic                           ready       [N+1];

   assign ready[N] = out_ready;

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int SHIFT = N - 1 - k;

      logic                        src_valid;
      logic [rgbp_pkg::REM_W-1:0]  src_rem;
      logic [rgbp_pkg::RAD2_W-1:0] src_divisor;
      logic [rgbp_pkg::QUOT_W-1:0] src_quot;
      logic                        src_in_glow;
      logic [rgbp_pkg::REM_W-1:0]  shifted;
      logic                        fits;
      logic                        valid_in;
      logic [rgbp_pkg::REM_W-1:0]  rem_in;
      logic [rgbp_pkg::QUOT_W-1:0] quot_in;

      if (k == 0) begin : g_first
         assign src_valid   = in_valid;
         assign src_rem     = in_data.dividend;
         assign src_divisor = in_data.divisor;
         assign src_quot    = '0;
         assign src_in_glow = in_data.in_glow;
      end else begin : g_next
         assign src_valid   = valid_ff[k-1];
         assign src_rem     = rem_ff[k-1];
         assign src_divisor = divisor_ff[k-1];
         assign src_quot    = quot_ff[k-1];
         assign src_in_glow = in_glow_ff[k-1];
      end

      assign ready[k] = !valid_ff[k] || ready[k+1];

      always_comb begin
         shifted  = rgbp_pkg::REM_W'(src_divisor) << SHIFT;
         fits     = (src_rem >= shifted);
         rem_in   = fits ? (src_rem - shifted) : src_rem;
         quot_in  = src_quot;
         quot_in[SHIFT] = fits;
         valid_in = ready[k] ? src_valid : valid_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) begin
            rem_ff[k]     <= rem_in;
            divisor_ff[k] <= src_divisor;
            quot_ff[k]    <= quot_in;
            in_glow_ff[k] <= src_in_glow;
         end
      end
   end

   assign in_ready         = ready[0];
   assign out_valid        = valid_ff[N-1];
   assign out_data.quot    = quot_ff[N-1];
   assign out_data.in_glow = in_glow_ff[N-1];

endmodule

/* rtl/core/radial_glow_backdrop_pixel.sv */
// Top level of the radial glow backdrop pixel block: geometry registers and the pixel pipeline.
// Depends on rgbp_pkg and instantiates rgbp_div_pipe.
//
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  pixel_x, pixel_y
//   rsp_        out        rsp_valid/rsp_stall  red, green, blue
//   csr_        in         csr_write_en         frame_width, frame_height
//
// One item per clock sustained while rsp_stall stays low; each item passes 11 register stages:
// offset, square, sum, compare and scale, six divider stages (one quotient bit each), color.
// Reset clears all valid bits and loads the 640 by 480 frame geometry.
// Each stage holds its item while the next one is full and stalled, so empty stages still
// take items while a finished result waits on rsp_stall.

module radial_glow_backdrop_pixel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rgbp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rgbp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [rgbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rgbp_pkg::CFG_W-1:0]          csr_wdata
);

   // Glow geometry, derived from the frame size when it is written.
   logic [rgbp_pkg::CX_W-1:0]   cx_ff;
   logic [rgbp_pkg::CY_W-1:0]   cy_ff;
   logic [rgbp_pkg::RAD_W-1:0]  radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= rgbp_pkg::CX_W'(rgbp_pkg::CX_RESET);
         cy_ff     <= rgbp_pkg::CY_W'(rgbp_pkg::CY_RESET);
         radius_ff <= rgbp_pkg::RAD_W'(rgbp_pkg::RADIUS_RESET);
      end else if (csr_write_en) begin
         case (rgbp_pkg::csr_index_type'(csr_index))
            rgbp_pkg::CSR_FRAME_WIDTH: begin
               cx_ff     <= rgbp_pkg::center_x(csr_wdata);
               radius_ff <= rgbp_pkg::glow_radius(csr_wdata);
            end
            rgbp_pkg::CSR_FRAME_HEIGHT: begin
               cy_ff <= csr_wdata[rgbp_pkg::CFG_W-1:3];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage ready chain, from the output back to the input.
   logic out_ready;
   logic a_ready;
   logic b_ready;
   logic c_ready;
   logic d_ready;
   logic div_in_ready;
   logic div_out_valid;
   rgbp_pkg::div_out_type div_out;

   logic a_valid_ff;
   logic b_valid_ff;
   logic c_valid_ff;
   logic d_valid_ff;
   logic rsp_valid_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign d_ready   = !d_valid_ff || div_in_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;

   // Stage A: absolute offsets from the glow center.
   logic [rgbp_pkg::DIFF_W-1:0] a_adx_ff;
   logic [rgbp_pkg::DIFF_W-1:0] a_ady_ff;
   logic [rgbp_pkg::DIFF_W-1:0] a_adx_in;
   logic [rgbp_pkg::DIFF_W-1:0] a_ady_in;

   always_comb begin
      logic [rgbp_pkg::DIFF_W-1:0] px;
      logic [rgbp_pkg::DIFF_W-1:0] py;
      logic [rgbp_pkg::DIFF_W-1:0] cx;
      logic [rgbp_pkg::DIFF_W-1:0] cy;
      px = rgbp_pkg::DIFF_W'(req_data.pixel_x);
      py = rgbp_pkg::DIFF_W'(req_data.pixel_y);
      cx = rgbp_pkg::DIFF_W'(cx_ff);
      cy = rgbp_pkg::DIFF_W'(cy_ff);
      a_adx_in = (px >= cx) ? (px - cx) : (cx - px);
      a_ady_in = (py >= cy) ? (py - cy) : (cy - py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_adx_ff <= a_adx_in;
         a_ady_ff <= a_ady_in;
      end
   end

   // Stage B: squares of both offsets and of the radius.
   logic [rgbp_pkg::SQ_W-1:0]   b_dx2_ff;
   logic [rgbp_pkg::SQ_W-1:0]   b_dy2_ff;
   logic [rgbp_pkg::RAD2_W-1:0] b_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_dx2_ff <= rgbp_pkg::SQ_W'(a_adx_ff) * rgbp_pkg::SQ_W'(a_adx_ff);
         b_dy2_ff <= rgbp_pkg::SQ_W'(a_ady_ff) * rgbp_pkg::SQ_W'(a_ady_ff);
         b_r2_ff  <= rgbp_pkg::RAD2_W'(radius_ff) * rgbp_pkg::RAD2_W'(radius_ff);
      end
   end

   // Stage C: squared distance.
   logic [rgbp_pkg::DIST_W-1:0] c_dist2_ff;
   logic [rgbp_pkg::RAD2_W-1:0] c_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_dist2_ff <= rgbp_pkg::DIST_W'(b_dx2_ff) + rgbp_pkg::DIST_W'(b_dy2_ff);
         c_r2_ff    <= b_r2_ff;
      end
   end

   // Stage D: glow test and dividend dist2*36; pixels outside the glow divide zero.
   rgbp_pkg::div_in_type d_div_ff;
   rgbp_pkg::div_in_type d_div_in;

   always_comb begin
      logic [rgbp_pkg::REM_W-1:0] d;
      d = rgbp_pkg::REM_W'(c_dist2_ff);
      d_div_in.in_glow  = (c_r2_ff != '0) &&
                          (rgbp_pkg::CMP_W'(c_dist2_ff) < rgbp_pkg::CMP_W'(c_r2_ff));
      d_div_in.dividend = d_div_in.in_glow ? ((d << 5) + (d << 2)) : '0;
      d_div_in.divisor  = c_r2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready) begin
         d_div_ff <= d_div_in;
      end
   end

   rgbp_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .in_ready  (div_in_ready),
      .in_data   (d_div_ff),
      .out_valid (div_out_valid),
      .out_ready (out_ready),
      .out_data  (div_out)
   );

   // Output stage: color from the glow intensity.
   rgbp_pkg::rsp_type rsp_data_ff;
   rgbp_pkg::rsp_type rsp_data_in;

   always_comb begin
      logic [rgbp_pkg::QUOT_W-1:0] intensity;
      intensity = rgbp_pkg::QUOT_W'(rgbp_pkg::INTENSITY_MAX) - div_out.quot;
      rsp_data_in.red   = rgbp_pkg::COLOR_W'(rgbp_pkg::BASE_RED);
      rsp_data_in.green = rgbp_pkg::COLOR_W'(rgbp_pkg::BASE_GREEN);
      rsp_data_in.blue  = rgbp_pkg::COLOR_W'(rgbp_pkg::BASE_BLUE);
      if (div_out.in_glow) begin
         rsp_data_in.green = rgbp_pkg::COLOR_W'(rgbp_pkg::BASE_GREEN)
                           + rgbp_pkg::COLOR_W'(intensity);
         rsp_data_in.blue  = rgbp_pkg::COLOR_W'(rgbp_pkg::BASE_BLUE)
                           + rgbp_pkg::COLOR_W'(rgbp_pkg::third(intensity));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
